FILE: hw/rtl/bts_pkg.sv
`timescale 1ns / 1ps

package bts_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_WRITE_DONE = 3'd1,
        FUNC_QSEL_DONE  = 3'd2,
        FUNC_QREAD_DONE = 3'd3,
        FUNC_READ_DONE  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    localparam logic [7:0] SLOTS_MIN   = 8'd1;
    localparam logic [7:0] SLOTS_MAX   = 8'd128;
    localparam logic [7:0] SLOTS_RESET = 8'd5;

    localparam logic [0:0] REG_WRITES_BEFORE_QUERY = 1'd0;

endpackage

FILE: hw/rtl/bridge_tx_rx_slot_scheduler_core.sv
`timescale 1ns / 1ps

// Transaction slot scheduler for a bridge.
// Input channel (s_*): one item per timer tick or per bus completion (write,
// query select, query read, read). Result channel (m_*): exactly one item per
// input item, giving the transaction to issue, its byte count, a refused flag,
// the new phase and the running byte totals.
// Pipeline: an input register feeds the decision logic, which writes the
// result register and the scheduler state in the same edge. A result passes
// through the input register and then the result register; one item per
// cycle is sustained when m_ready stays high.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages and sets phase 0, not
// busy, 5 write slots per round, no pending receive bytes and zero totals.
// APB register 0 (writes_before_query) is clamped to 1..128 on write and
// adopted by the next tick that finds phase zero, the link up and not busy.
module bridge_tx_rx_slot_scheduler_core #(
    parameter int MAX_PAYLOAD = 32,
    parameter int FIFO_DEPTH  = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic        s_link_connected,
    input  logic        s_engine_ready,
    input  logic [8:0]  s_tx_fill,
    input  logic [8:0]  s_rx_space,
    input  logic        s_status_ok,
    input  logic [7:0]  s_partner_count,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_byte_count,
    output logic        m_refused,
    output logic [7:0]  m_phase_now,
    output logic [31:0] m_sent_total,
    output logic [31:0] m_received_total,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bts_pkg::*;

    localparam logic [7:0] MAX_PL = 8'(MAX_PAYLOAD);
    localparam logic [8:0] DEPTH  = 9'(FIFO_DEPTH);

    // input stage
    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic        in_link_reg;
    logic        in_eng_ready_reg;
    logic [8:0]  in_tx_fill_reg;
    logic [8:0]  in_rx_space_reg;
    logic        in_ok_reg;
    logic [7:0]  in_pcount_reg;

    // result stage
    logic        out_valid_reg;
    logic [1:0]  out_action_reg;
    logic [7:0]  out_count_reg;
    logic        out_refused_reg;

    // scheduler state
    logic [7:0]  phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic [7:0]  active_writes_reg, active_writes_next;
    logic [7:0]  pending_rx_reg, pending_rx_next;
    logic [31:0] tx_total_reg, tx_total_next;
    logic [31:0] rx_total_reg, rx_total_next;
    logic [7:0]  wbq_reg;
    logic        slots_pending_reg, slots_pending_next;

    logic [1:0]  action_next;
    logic [7:0]  count_next;
    logic        refused_next;

    logic        out_adv;
    logic        in_adv;
    logic        cfg_wr;
    logic [7:0]  cfg_clamped;

    assign out_adv = !out_valid_reg || m_ready;
    assign in_adv  = in_valid_reg && out_adv;
    assign s_ready = !in_valid_reg || out_adv;

    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_WRITES_BEFORE_QUERY);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_WRITES_BEFORE_QUERY) ? {24'd0, wbq_reg} : 32'd0;

    always_comb begin
        cfg_clamped = pwdata[7:0];
        if (cfg_clamped < SLOTS_MIN) begin
            cfg_clamped = SLOTS_MIN;
        end
        if (cfg_clamped > SLOTS_MAX) begin
            cfg_clamped = SLOTS_MAX;
        end
    end

    always_comb begin
        logic [8:0] tx_sat;
        logic [8:0] rx_sat;
        logic [7:0] n;
        logic       to_query;

        tx_sat = (in_tx_fill_reg > DEPTH) ? DEPTH : in_tx_fill_reg;
        rx_sat = (in_rx_space_reg > DEPTH) ? DEPTH : in_rx_space_reg;
        n      = 8'd0;
        to_query = 1'b0;

        phase_next         = phase_reg;
        busy_next          = busy_reg;
        active_writes_next = active_writes_reg;
        pending_rx_next    = pending_rx_reg;
        tx_total_next      = tx_total_reg;
        rx_total_next      = rx_total_reg;
        slots_pending_next = slots_pending_reg;
        action_next        = ACT_NONE;
        count_next         = 8'd0;
        refused_next       = 1'b0;

        unique case (in_func_reg)
            FUNC_TICK: begin
                if (in_link_reg && !busy_reg) begin
                    if (phase_reg < active_writes_reg) begin
                        if (phase_reg == 8'd0 && slots_pending_reg) begin
                            active_writes_next = wbq_reg;
                            slots_pending_next = 1'b0;
                        end
                        if (tx_sat == 9'd0) begin
                            phase_next = active_writes_next;
                            to_query   = 1'b1;
                        end else begin
                            n = (tx_sat > {1'b0, MAX_PL}) ? MAX_PL : tx_sat[7:0];
                            if (!in_eng_ready_reg) begin
                                refused_next = 1'b1;
                            end else begin
                                tx_total_next = tx_total_reg + {24'd0, n};
                                busy_next     = 1'b1;
                                action_next   = ACT_WRITE;
                                count_next    = n;
                            end
                        end
                    end
                    // phase_next equals phase_reg here unless the query jump fired
                    if (to_query || phase_next == active_writes_next) begin
                        if (rx_sat == 9'd0) begin
                            phase_next = 8'd0;
                        end else if (!in_eng_ready_reg) begin
                            refused_next = 1'b1;
                        end else begin
                            busy_next   = 1'b1;
                            action_next = ACT_QUERY;
                        end
                    end else if (phase_next > active_writes_next) begin
                        if (pending_rx_reg == 8'd0 || rx_sat == 9'd0) begin
                            phase_next = 8'd0;
                        end else begin
                            n = (pending_rx_reg > MAX_PL) ? MAX_PL : pending_rx_reg;
                            if ({1'b0, n} > rx_sat) begin
                                n = rx_sat[7:0];
                            end
                            // a refused read still consumes the pending count
                            pending_rx_next = pending_rx_reg - n;
                            if (!in_eng_ready_reg) begin
                                refused_next = 1'b1;
                            end else begin
                                rx_total_next = rx_total_reg + {24'd0, n};
                                busy_next     = 1'b1;
                                action_next   = ACT_READ;
                                count_next    = n;
                            end
                        end
                    end
                end
            end
            FUNC_WRITE_DONE: begin
                busy_next = 1'b0;
                if (in_ok_reg) begin
                    phase_next = phase_reg + 8'd1;
                end
            end
            FUNC_QSEL_DONE: begin
                if (!in_ok_reg) begin
                    busy_next  = 1'b0;
                    phase_next = 8'd0;
                end
            end
            FUNC_QREAD_DONE: begin
                busy_next = 1'b0;
                if (in_ok_reg) begin
                    pending_rx_next = in_pcount_reg;
                    phase_next = (in_pcount_reg != 8'd0) ? (phase_reg + 8'd1) : 8'd0;
                end else begin
                    phase_next = 8'd0;
                end
            end
            FUNC_READ_DONE: begin
                busy_next = 1'b0;
                if (in_ok_reg && pending_rx_reg != 8'd0) begin
                    phase_next = active_writes_reg + 8'd1;
                end else begin
                    phase_next = 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= 8'd0;
            busy_reg          <= 1'b0;
            active_writes_reg <= SLOTS_RESET;
            pending_rx_reg    <= 8'd0;
            tx_total_reg      <= 32'd0;
            rx_total_reg      <= 32'd0;
            wbq_reg           <= SLOTS_RESET;
            slots_pending_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (in_adv) begin
                in_valid_reg <= 1'b0;
            end

            if (in_adv) begin
                out_valid_reg     <= 1'b1;
                phase_reg         <= phase_next;
                busy_reg          <= busy_next;
                active_writes_reg <= active_writes_next;
                pending_rx_reg    <= pending_rx_next;
                tx_total_reg      <= tx_total_next;
                rx_total_reg      <= rx_total_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                wbq_reg           <= cfg_clamped;
                slots_pending_reg <= 1'b1;
            end else if (in_adv) begin
                slots_pending_reg <= slots_pending_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg      <= s_func;
            in_link_reg      <= s_link_connected;
            in_eng_ready_reg <= s_engine_ready;
            in_tx_fill_reg   <= s_tx_fill;
            in_rx_space_reg  <= s_rx_space;
            in_ok_reg        <= s_status_ok;
            in_pcount_reg    <= s_partner_count;
        end
        if (in_adv) begin
            out_action_reg  <= action_next;
            out_count_reg   <= count_next;
            out_refused_reg <= refused_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_action         = out_action_reg;
    assign m_byte_count     = out_count_reg;
    assign m_refused        = out_refused_reg;
    assign m_phase_now      = phase_reg;
    assign m_sent_total     = tx_total_reg;
    assign m_received_total = rx_total_reg;

    a_refused_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_refused_reg |-> out_action_reg == ACT_NONE)
        else $error("refused item carries an action");

    a_count_only_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_count_reg != 8'd0 |->
            (out_action_reg == ACT_WRITE || out_action_reg == ACT_READ))
        else $error("byte count without a write or read");

    a_busy_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_adv && busy_reg && in_func_reg == FUNC_TICK |=>
            out_action_reg == ACT_NONE && !out_refused_reg && $stable(phase_reg))
        else $error("tick acted while busy");

    a_slots_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_writes_reg >= SLOTS_MIN && active_writes_reg <= SLOTS_MAX)
        else $error("write slot count out of range");

endmodule

FILE: dv/tb_bridge_tx_rx_slot_scheduler_core.sv
`timescale 1ns / 1ps

module tb_bridge_tx_rx_slot_scheduler_core;
    import bts_pkg::*;

    localparam int PAYLOAD_MAX   = 32;
    localparam int DEPTH         = 256;
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [2:0] ADDR_SLOTS  = {REG_WRITES_BEFORE_QUERY, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic       link_connected;
        logic       engine_ready;
        logic [8:0] tx_fill;
        logic [8:0] rx_space;
        logic       status_ok;
        logic [7:0] partner_count;
    } sched_item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  byte_count;
        logic        refused;
        logic [7:0]  phase_now;
        logic [31:0] sent_total;
        logic [31:0] received_total;
    } decision_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic        s_link_connected = 1'b0;
    logic        s_engine_ready = 1'b0;
    logic [8:0]  s_tx_fill = '0;
    logic [8:0]  s_rx_space = '0;
    logic        s_status_ok = 1'b0;
    logic [7:0]  s_partner_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_action;
    logic [7:0]  m_byte_count;
    logic        m_refused;
    logic [7:0]  m_phase_now;
    logic [31:0] m_sent_total;
    logic [31:0] m_received_total;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // scheduler state as the testbench sees it
    logic [7:0]  sch_phase;
    logic        sch_busy;
    logic [7:0]  sch_slots;
    logic [7:0]  sch_pending_rx;
    logic [31:0] sch_sent;
    logic [31:0] sch_received;
    logic [7:0]  sch_slot_cfg;
    logic        sch_cfg_pending;

    // completion the bus engine owes next, used to shape stimulus
    func_t       owed_done;
    logic        done_owed;

    decision_t   decision_q[$];
    decision_t   oldest;
    int          err_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;

    bridge_tx_rx_slot_scheduler_core #(
        .MAX_PAYLOAD(PAYLOAD_MAX),
        .FIFO_DEPTH (DEPTH)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_link_connected(s_link_connected),
        .s_engine_ready  (s_engine_ready),
        .s_tx_fill       (s_tx_fill),
        .s_rx_space      (s_rx_space),
        .s_status_ok     (s_status_ok),
        .s_partner_count (s_partner_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_byte_count    (m_byte_count),
        .m_refused       (m_refused),
        .m_phase_now     (m_phase_now),
        .m_sent_total    (m_sent_total),
        .m_received_total(m_received_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decision_q.size() == 0) begin
                err_count++;
                $display("%0t: result item with none expected, actual action %0d phase %0d",
                         $time, m_action, m_phase_now);
            end else begin
                oldest = decision_q.pop_front();
                check_field("action", 32'(oldest.action), 32'(m_action));
                check_field("byte_count", 32'(oldest.byte_count), 32'(m_byte_count));
                check_field("refused", 32'(oldest.refused), 32'(m_refused));
                check_field("phase_now", 32'(oldest.phase_now), 32'(m_phase_now));
                check_field("sent_total", oldest.sent_total, m_sent_total);
                check_field("received_total", oldest.received_total, m_received_total);
            end
        end
    end

    function automatic logic [8:0] sat_depth(input logic [8:0] v);
        return (v > DEPTH) ? 9'(DEPTH) : v;
    endfunction

    // advances the scheduler state by one item and returns the decision it makes
    function automatic decision_t slot_decision(input sched_item_t it);
        decision_t  d;
        logic [8:0] txf;
        logic [8:0] rxs;
        logic [7:0] n;
        logic       to_query;
        d.action = ACT_NONE;
        d.byte_count = '0;
        d.refused = 1'b0;
        txf = sat_depth(it.tx_fill);
        rxs = sat_depth(it.rx_space);
        to_query = 1'b0;
        case (it.func)
            FUNC_TICK: begin
                if (it.link_connected && !sch_busy) begin
                    if (sch_phase < sch_slots) begin
                        if (sch_phase == 0 && sch_cfg_pending) begin
                            sch_slots = sch_slot_cfg;
                            sch_cfg_pending = 1'b0;
                        end
                        if (txf == 0) begin
                            // empty transmit side: skip straight to the query slot
                            sch_phase = sch_slots;
                            to_query = 1'b1;
                        end else begin
                            n = (txf > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : txf[7:0];
                            if (!it.engine_ready) begin
                                d.refused = 1'b1;
                            end else begin
                                sch_sent += n;
                                sch_busy = 1'b1;
                                d.action = ACT_WRITE;
                                d.byte_count = n;
                            end
                        end
                    end
                    if (to_query || sch_phase == sch_slots) begin
                        if (rxs == 0) begin
                            sch_phase = '0;
                        end else if (!it.engine_ready) begin
                            d.refused = 1'b1;
                        end else begin
                            sch_busy = 1'b1;
                            d.action = ACT_QUERY;
                        end
                    end else if (sch_phase > sch_slots) begin
                        if (sch_pending_rx == 0 || rxs == 0) begin
                            sch_phase = '0;
                        end else begin
                            n = (sch_pending_rx > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX)
                                                               : sch_pending_rx;
                            if (n > rxs) n = rxs[7:0];
                            // a refused read still consumes the pending count
                            sch_pending_rx -= n;
                            if (!it.engine_ready) begin
                                d.refused = 1'b1;
                            end else begin
                                sch_received += n;
                                sch_busy = 1'b1;
                                d.action = ACT_READ;
                                d.byte_count = n;
                            end
                        end
                    end
                end
            end
            FUNC_WRITE_DONE: begin
                sch_busy = 1'b0;
                if (it.status_ok) sch_phase = sch_phase + 8'd1;
            end
            FUNC_QSEL_DONE: begin
                if (!it.status_ok) begin
                    sch_busy = 1'b0;
                    sch_phase = '0;
                end
            end
            FUNC_QREAD_DONE: begin
                sch_busy = 1'b0;
                if (it.status_ok) begin
                    sch_pending_rx = it.partner_count;
                    sch_phase = (it.partner_count != 0) ? sch_phase + 8'd1 : 8'd0;
                end else begin
                    sch_phase = '0;
                end
            end
            FUNC_READ_DONE: begin
                sch_busy = 1'b0;
                if (it.status_ok && sch_pending_rx != 0) sch_phase = sch_slots + 8'd1;
                else sch_phase = '0;
            end
            default: ;
        endcase
        d.phase_now = sch_phase;
        d.sent_total = sch_sent;
        d.received_total = sch_received;
        return d;
    endfunction

    function automatic sched_item_t make_item(input logic [2:0] func, input logic link,
                                              input logic rdy, input logic [8:0] tx,
                                              input logic [8:0] rx, input logic ok,
                                              input logic [7:0] pc);
        sched_item_t it;
        it.func = func;
        it.link_connected = link;
        it.engine_ready = rdy;
        it.tx_fill = tx;
        it.rx_space = rx;
        it.status_ok = ok;
        it.partner_count = pc;
        return it;
    endfunction

    function automatic logic [8:0] pick_fill(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        if (r < 85) return 9'($urandom_range(1, 40));
        return 9'($urandom_range(0, 511));
    endfunction

    // mostly what a bus engine would send next; the rest is plain noise
    function automatic sched_item_t next_item();
        sched_item_t it;
        it = make_item(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                       9'($urandom), 9'($urandom), 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 99) < 85) begin
            if (sch_busy) begin
                it.func = done_owed ? owed_done : 3'($urandom_range(1, 4));
                it.status_ok = ($urandom_range(0, 99) < 90);
                if ($urandom_range(0, 9) == 0) it.partner_count = '0;
                else if ($urandom_range(0, 1) == 0)
                    it.partner_count = 8'($urandom_range(1, 40));
            end else begin
                it.func = FUNC_TICK;
                it.link_connected = ($urandom_range(0, 99) < 95);
                it.engine_ready = ($urandom_range(0, 99) < 85);
                it.tx_fill = pick_fill(15);
                it.rx_space = pick_fill(10);
            end
        end
        return it;
    endfunction

    task automatic send_item(input sched_item_t it);
        decision_t d;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_func <= it.func;
        s_link_connected <= it.link_connected;
        s_engine_ready <= it.engine_ready;
        s_tx_fill <= it.tx_fill;
        s_rx_space <= it.rx_space;
        s_status_ok <= it.status_ok;
        s_partner_count <= it.partner_count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        d = slot_decision(it);
        decision_q.push_back(d);
        case (d.action)
            ACT_WRITE: begin owed_done = FUNC_WRITE_DONE; done_owed = 1'b1; end
            ACT_QUERY: begin owed_done = FUNC_QSEL_DONE;  done_owed = 1'b1; end
            ACT_READ:  begin owed_done = FUNC_READ_DONE;  done_owed = 1'b1; end
            default: begin
                if (it.func == FUNC_QSEL_DONE && sch_busy) begin
                    owed_done = FUNC_QREAD_DONE;
                    done_owed = 1'b1;
                end else if (!sch_busy) begin
                    done_owed = 1'b0;
                end
            end
        endcase
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (decision_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        logic [7:0] c;
        settle_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SLOTS) begin
            c = value[7:0];
            if (c < SLOTS_MIN) c = SLOTS_MIN;
            if (c > SLOTS_MAX) c = SLOTS_MAX;
            sch_slot_cfg = c;
            sch_cfg_pending = 1'b1;
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 26;
        rx_stall_pct = 50;
        send_item(make_item(FUNC_TICK, 1'b0, 1'b1, 9'd20, 9'd20, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b0, 9'd511, 9'd20, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd511, 9'd20, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd10, 9'd20, 1'b1, 8'd0));
        send_item(make_item(FUNC_WRITE_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b0, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd7, 9'd20, 1'b1, 8'd0));
        send_item(make_item(FUNC_WRITE_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b0, 9'd0, 9'd256, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd0, 9'd511, 1'b1, 8'd0));
        send_item(make_item(FUNC_QSEL_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd0));
        send_item(make_item(FUNC_QREAD_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd255));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b0, 9'd3, 9'd511, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd3, 9'd5, 1'b1, 8'd0));
        send_item(make_item(FUNC_READ_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd0));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd3, 9'd0, 1'b1, 8'd0));
        // codes past the last completion are ignored
        send_item(make_item(3'd5, 1'b1, 1'b1, 9'd3, 9'd3, 1'b1, 8'd9));
        send_item(make_item(3'd6, 1'b1, 1'b1, 9'd3, 9'd3, 1'b1, 8'd9));
        send_item(make_item(3'd7, 1'b1, 1'b1, 9'd3, 9'd3, 1'b1, 8'd9));
        send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd0));
        // completions that arrive out of order
        send_item(make_item(FUNC_WRITE_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd0));
        send_item(make_item(FUNC_QSEL_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b0, 8'd0));
        send_item(make_item(FUNC_QREAD_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b1, 8'd0));
        send_item(make_item(FUNC_QREAD_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b0, 8'd77));
        send_item(make_item(FUNC_READ_DONE, 1'b1, 1'b1, 9'd0, 9'd0, 1'b0, 8'd0));
    endtask

    task automatic test_slot_config(input logic [31:0] value);
        apb_write(ADDR_SLOTS, value);
    endtask

    task automatic test_unused_register();
        apb_write(ADDR_UNUSED, 32'($urandom));
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        send_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (count) send_item(next_item());
    endtask

    // long receiver hold-off while items keep coming, so the input backs up
    task automatic test_backpressure(input int count, input int hold_cycles);
        send_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = hold_cycles;
        repeat (count) send_item(next_item());
    endtask

    initial begin
        sch_phase = '0;
        sch_busy = 1'b0;
        sch_slots = SLOTS_RESET;
        sch_pending_rx = '0;
        sch_sent = '0;
        sch_received = '0;
        sch_slot_cfg = SLOTS_RESET;
        sch_cfg_pending = 1'b0;
        done_owed = 1'b0;
        owed_done = FUNC_WRITE_DONE;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_slot_config(32'd0);
        test_random_traffic(300, 26, 50);
        test_slot_config(32'hFFFF_FF80);
        test_random_traffic(300, 26, 50);
        test_slot_config(32'd200);
        test_random_traffic(300, 50, 26);
        test_unused_register();
        test_slot_config(32'($urandom_range(1, 128)) | 32'($urandom) << 8);
        test_random_traffic(300, 50, 26);
        test_slot_config(32'd5);
        test_random_traffic(300, 0, 0);
        test_slot_config(32'd2);
        test_backpressure(40, 80);
        test_random_traffic(250, 0, 0);

        settle_idle();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bts_pkg.sv
hw/rtl/bridge_tx_rx_slot_scheduler_core.sv
dv/tb_bridge_tx_rx_slot_scheduler_core.sv
